// ----- rtl/pjs_pkg.sv -----
// Shared types and codes of the per-connection job serializer.
// Depends on nothing; imported by pjs_decide, the top level, the result checker and the testbench.
package pjs_pkg;

    // Connection field width and the number of codes it can carry
    localparam int CONN_PORT_W = 6;
    localparam int CONN_CODES  = 64;

    typedef enum logic {
        ACT_SUBMIT = 1'b0,
        ACT_DONE   = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_DECODE = 2'd1,
        KIND_DRAIN  = 2'd2,
        KIND_CLOSE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_DISPATCHED       = 3'd0,
        ST_BACKLOGGED       = 3'd1,
        ST_PENDING_STORED   = 3'd2,
        ST_PENDING_REPLACED = 3'd3,
        ST_BACKLOG_FULL     = 3'd4,
        ST_DONE_UNKNOWN     = 3'd5,
        ST_IDLE             = 3'd6
    } status_t;

    // Where the tag of a dispatched job comes from
    typedef enum logic [2:0] {
        SRC_NONE    = 3'd0,
        SRC_INPUT   = 3'd1,
        SRC_DECODE  = 3'd2,
        SRC_DRAIN   = 3'd3,
        SRC_BACKLOG = 3'd4
    } src_t;

    // Control view of one connection entry
    typedef struct packed {
        logic active;
        logic prefer;
        logic dec_v;
        logic drn_v;
        logic bl_empty;
        logic bl_full;
    } pjs_flags_t;

    // Outcome of one request for one connection
    typedef struct packed {
        status_t status;
        kind_t   kind;
        src_t    src;
        logic    active;
        logic    prefer;
        logic    dec_v;
        logic    drn_v;
        logic    wr_dec_tag;
        logic    wr_drn_tag;
        logic    push;
        logic    pop;
        logic    go_idle;
    } pjs_decision_t;

endpackage

// ----- rtl/pjs_decide.sv -----
// Decision logic of the job serializer: turns one request and the control
// flags of its connection into the status and the entry updates. Uses pjs_pkg.
module pjs_decide import pjs_pkg::*; (
    input  action_t       action,
    input  kind_t         kind,
    input  pjs_flags_t    flags,
    output pjs_decision_t dec
);

    always_comb
    begin
        dec            = '0;
        dec.status     = ST_DONE_UNKNOWN;
        dec.kind       = KIND_ACCEPT;
        dec.src        = SRC_NONE;
        dec.active     = flags.active;
        dec.prefer     = flags.prefer;
        dec.dec_v      = flags.dec_v;
        dec.drn_v      = flags.drn_v;

        unique case (action)
            ACT_SUBMIT:
            begin
                if (!flags.active)
                begin
                    // idle connection: dispatch at once
                    dec.active = 1'b1;
                    dec.status = ST_DISPATCHED;
                    dec.kind   = kind;
                    dec.src    = SRC_INPUT;
                end
                else
                begin
                    unique case (kind) inside
                        KIND_DECODE:
                        begin
                            dec.wr_dec_tag = 1'b1;
                            dec.dec_v      = 1'b1;
                            dec.status     = flags.dec_v ? ST_PENDING_REPLACED
                                                         : ST_PENDING_STORED;
                        end
                        KIND_DRAIN:
                        begin
                            dec.wr_drn_tag = 1'b1;
                            dec.drn_v      = 1'b1;
                            dec.status     = flags.drn_v ? ST_PENDING_REPLACED
                                                         : ST_PENDING_STORED;
                        end
                        KIND_ACCEPT, KIND_CLOSE:
                        begin
                            if (flags.bl_full)
                            begin
                                dec.status = ST_BACKLOG_FULL;
                            end
                            else
                            begin
                                dec.push   = 1'b1;
                                dec.status = ST_BACKLOGGED;
                            end
                        end
                    endcase
                end
            end
            ACT_DONE:
            begin
                if (!flags.active)
                begin
                    dec.status = ST_DONE_UNKNOWN;
                end
                else if (flags.drn_v && (!flags.dec_v || flags.prefer))
                begin
                    dec.drn_v  = 1'b0;
                    dec.prefer = 1'b0;
                    dec.status = ST_DISPATCHED;
                    dec.kind   = KIND_DRAIN;
                    dec.src    = SRC_DRAIN;
                end
                else if (flags.dec_v)
                begin
                    dec.dec_v  = 1'b0;
                    dec.prefer = 1'b1;
                    dec.status = ST_DISPATCHED;
                    dec.kind   = KIND_DECODE;
                    dec.src    = SRC_DECODE;
                end
                else if (!flags.bl_empty)
                begin
                    // kind comes with the backlog word
                    dec.pop    = 1'b1;
                    dec.status = ST_DISPATCHED;
                    dec.src    = SRC_BACKLOG;
                end
                else
                begin
                    dec.active  = 1'b0;
                    dec.prefer  = 1'b0;
                    dec.go_idle = 1'b1;
                    dec.status  = ST_IDLE;
                end
            end
        endcase
    end

endmodule

// ----- rtl/per_connection_job_serializer.sv -----
// Top level of the per-connection job serializer: connection table memory,
// backlog memory, sequencer and result register. Uses pjs_pkg and pjs_decide.
//
// A request is taken when start is high and busy is low; every request gives
// exactly one result, shown for one cycle with result_valid high. The receiver
// cannot hold results off, so each result must be captured in the cycle it is
// shown. A request is handled in steps before the next one can be taken: the
// synchronous read of the connection table on acceptance, then the update of
// the entry and the registering of the result. A done that hands out a job
// from the backlog adds the read of the backlog memory as a further step, its
// address depending on the head pointer just read. After reset, busy stays
// high while the connection table is swept clear, one entry a cycle.
// Connection numbers at or above CONNECTIONS wrap modulo CONNECTIONS.
module per_connection_job_serializer import pjs_pkg::*; #(
    parameter int CONNECTIONS   = 64,
    parameter int BACKLOG_DEPTH = 8,
    parameter int TAG_BITS      = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   action,
    input  logic [CONN_PORT_W-1:0] connection,
    input  logic [1:0]             job_kind,
    input  logic [TAG_BITS-1:0]    job_tag,
    output logic                   result_valid,
    output logic [2:0]             status,
    output logic [CONN_PORT_W-1:0] out_connection,
    output logic [1:0]             out_kind,
    output logic [TAG_BITS-1:0]    out_tag
);

    localparam int IDX_W    = $clog2(CONNECTIONS);
    localparam int HEAD_W   = (BACKLOG_DEPTH > 1) ? $clog2(BACKLOG_DEPTH) : 1;
    localparam int CNT_W    = $clog2(BACKLOG_DEPTH + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int BL_DEPTH = CONNECTIONS * BACKLOG_DEPTH;
    localparam int BL_AW    = (BL_DEPTH > 1) ? $clog2(BL_DEPTH) : 1;
    localparam int BL_W     = TAG_BITS + 1;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_LOOKUP = 4'b0100,
        S_POP    = 4'b1000
    } state_t;

    // One connection table entry
    typedef struct packed {
        logic                active;
        logic                prefer;
        logic                dec_v;
        logic                drn_v;
        logic [HEAD_W-1:0]   head;
        logic [CNT_W-1:0]    count;
        logic [TAG_BITS-1:0] dec_tag;
        logic [TAG_BITS-1:0] drn_tag;
    } entry_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                  valid_reg, valid_next;

    action_t               req_action_reg;
    logic [IDX_W-1:0]      req_conn_reg;
    kind_t                 req_kind_reg;
    logic [TAG_BITS-1:0]   req_tag_reg;

    entry_t                conn_mem [CONNECTIONS];
    entry_t                entry_rd_reg;
    logic [BL_W-1:0]       bl_mem [BL_DEPTH];
    logic [BL_W-1:0]       bl_rd_reg;

    status_t               status_reg, status_next;
    logic [CONN_PORT_W-1:0] conn_out_reg, conn_out_next;
    kind_t                 kind_reg, kind_next;
    logic [TAG_BITS-1:0]   tag_reg, tag_next;

    logic                  accept;
    logic [IDX_W-1:0]      conn_map [CONN_CODES];
    logic [IDX_W-1:0]      conn_idx;
    logic [IDX_W+CONN_PORT_W-1:0] conn_wide;

    pjs_flags_t            flags;
    pjs_decision_t         dec;
    entry_t                entry_upd;
    logic [SUM_W-1:0]      tail_sum;
    logic [SUM_W-1:0]      head_inc;
    logic [HEAD_W-1:0]     tail_slot;
    logic [HEAD_W-1:0]     head_wrap;
    logic [HEAD_W-1:0]     bl_slot;
    logic [BL_AW-1:0]      bl_addr;
    logic                  bl_we;
    logic                  bl_re;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    entry_t                mem_wdata;

    // Fold the connection number onto the table: small constant table
    for (genvar g = 0; g < CONN_CODES; g++)
    begin : g_conn_map
        assign conn_map[g] = IDX_W'(g % CONNECTIONS);
    end

    assign conn_idx  = conn_map[connection];
    assign conn_wide = {{CONN_PORT_W{1'b0}}, req_conn_reg};
    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;

    // Control view of the entry just read
    assign flags.active   = entry_rd_reg.active;
    assign flags.prefer   = entry_rd_reg.prefer;
    assign flags.dec_v    = entry_rd_reg.dec_v;
    assign flags.drn_v    = entry_rd_reg.drn_v;
    assign flags.bl_empty = (entry_rd_reg.count == '0);
    assign flags.bl_full  = (entry_rd_reg.count == CNT_W'(BACKLOG_DEPTH));

    pjs_decide u_decide (
        .action (req_action_reg),
        .kind   (req_kind_reg),
        .flags  (flags),
        .dec    (dec)
    );

    // Backlog ring positions; both sums stay below twice the depth
    assign tail_sum  = SUM_W'(entry_rd_reg.head) + SUM_W'(entry_rd_reg.count);
    assign tail_slot = (tail_sum >= SUM_W'(BACKLOG_DEPTH))
                       ? HEAD_W'(tail_sum - SUM_W'(BACKLOG_DEPTH))
                       : HEAD_W'(tail_sum);
    assign head_inc  = SUM_W'(entry_rd_reg.head) + SUM_W'(1);
    assign head_wrap = (head_inc == SUM_W'(BACKLOG_DEPTH)) ? '0 : HEAD_W'(head_inc);
    assign bl_slot   = dec.pop ? entry_rd_reg.head : tail_slot;
    assign bl_addr   = BL_AW'(req_conn_reg) * BL_AW'(BACKLOG_DEPTH) + BL_AW'(bl_slot);

    assign bl_we = (state_reg == S_LOOKUP) && dec.push;
    assign bl_re = (state_reg == S_LOOKUP) && dec.pop;

    // Modified entry to write back
    always_comb
    begin
        entry_upd        = entry_rd_reg;
        entry_upd.active = dec.active;
        entry_upd.prefer = dec.prefer;
        entry_upd.dec_v  = dec.dec_v;
        entry_upd.drn_v  = dec.drn_v;
        if (dec.wr_dec_tag)
        begin
            entry_upd.dec_tag = req_tag_reg;
        end
        if (dec.wr_drn_tag)
        begin
            entry_upd.drn_tag = req_tag_reg;
        end
        if (dec.push)
        begin
            entry_upd.count = entry_rd_reg.count + CNT_W'(1);
        end
        if (dec.pop)
        begin
            entry_upd.count = entry_rd_reg.count - CNT_W'(1);
            entry_upd.head  = head_wrap;
        end
        if (dec.go_idle)
        begin
            entry_upd.head = '0;
        end
    end

    // Table write port: clearing sweep or write-back of the current request
    assign mem_we    = (state_reg == S_CLEAR) || (state_reg == S_LOOKUP);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : req_conn_reg;
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : entry_upd;

    // Sequencer and result selection
    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        valid_next    = 1'b0;
        status_next   = status_reg;
        conn_out_next = conn_out_reg;
        kind_next     = kind_reg;
        tag_next      = tag_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == IDX_W'(CONNECTIONS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (dec.src == SRC_BACKLOG)
                begin
                    // hold the result until the backlog word arrives
                    state_next = S_POP;
                end
                else
                begin
                    state_next    = S_IDLE;
                    valid_next    = 1'b1;
                    status_next   = dec.status;
                    conn_out_next = '0;
                    kind_next     = KIND_ACCEPT;
                    tag_next      = '0;
                    if (dec.status == ST_DISPATCHED)
                    begin
                        conn_out_next = conn_wide[CONN_PORT_W-1:0];
                        kind_next     = dec.kind;
                        case (dec.src)
                            SRC_DECODE: tag_next = entry_rd_reg.dec_tag;
                            SRC_DRAIN:  tag_next = entry_rd_reg.drn_tag;
                            default:    tag_next = req_tag_reg;
                        endcase
                    end
                end
            end
            S_POP:
            begin
                state_next    = S_IDLE;
                valid_next    = 1'b1;
                status_next   = ST_DISPATCHED;
                conn_out_next = conn_wide[CONN_PORT_W-1:0];
                kind_next     = bl_rd_reg[TAG_BITS] ? KIND_CLOSE : KIND_ACCEPT;
                tag_next      = bl_rd_reg[TAG_BITS-1:0];
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            valid_reg   <= valid_next;
        end
    end

    // Request capture and result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_action_reg <= ACT_SUBMIT;
            req_conn_reg   <= '0;
            req_kind_reg   <= KIND_ACCEPT;
            req_tag_reg    <= '0;
            status_reg     <= ST_DISPATCHED;
            conn_out_reg   <= '0;
            kind_reg       <= KIND_ACCEPT;
            tag_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                req_action_reg <= action_t'(action);
                req_conn_reg   <= conn_idx;
                req_kind_reg   <= kind_t'(job_kind);
                req_tag_reg    <= job_tag;
            end
            status_reg   <= status_next;
            conn_out_reg <= conn_out_next;
            kind_reg     <= kind_next;
            tag_reg      <= tag_next;
        end
    end

    // Connection table: read on acceptance, write during sweep or write-back
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            conn_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            entry_rd_reg <= conn_mem[conn_idx];
        end
    end

    // Backlog memory: append on submit, read the head on done
    always_ff @(posedge clk)
    begin
        if (bl_we)
        begin
            bl_mem[bl_addr] <= {(req_kind_reg == KIND_CLOSE), req_tag_reg};
        end
        if (bl_re)
        begin
            bl_rd_reg <= bl_mem[bl_addr];
        end
    end

    assign result_valid   = valid_reg;
    assign status         = status_reg;
    assign out_connection = conn_out_reg;
    assign out_kind       = kind_reg;
    assign out_tag        = tag_reg;

endmodule

// ----- test/pjs_result_checker.sv -----
// Result checker for the per-connection job serializer: predicts every result
// from the accepted requests and compares. Uses pjs_pkg.
module pjs_result_checker import pjs_pkg::*; #(
    parameter int CONNECTIONS   = 64,
    parameter int BACKLOG_DEPTH = 8,
    parameter int TAG_BITS      = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic                   action,
    input  logic [CONN_PORT_W-1:0] connection,
    input  logic [1:0]             job_kind,
    input  logic [TAG_BITS-1:0]    job_tag,
    input  logic                   result_valid,
    input  logic [2:0]             status,
    input  logic [CONN_PORT_W-1:0] out_connection,
    input  logic [1:0]             out_kind,
    input  logic [TAG_BITS-1:0]    out_tag,
    output int                     fail_count,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Results still owed by the block; a handful at most
    localparam int RING_DEPTH = 16;

    typedef struct {
        status_t                status;
        logic [CONN_PORT_W-1:0] conn;
        kind_t                  kind;
        logic [TAG_BITS-1:0]    tag;
    } job_result_t;

    // Shadow of the per-connection job table
    logic                conn_active  [CONNECTIONS];
    logic                prefer_drain [CONNECTIONS];
    logic                decode_held  [CONNECTIONS];
    logic [TAG_BITS-1:0] decode_tag   [CONNECTIONS];
    logic                drain_held   [CONNECTIONS];
    logic [TAG_BITS-1:0] drain_tag    [CONNECTIONS];
    kind_t               backlog_kind [CONNECTIONS][BACKLOG_DEPTH];
    logic [TAG_BITS-1:0] backlog_tag  [CONNECTIONS][BACKLOG_DEPTH];
    int                  backlog_head [CONNECTIONS];
    int                  backlog_fill [CONNECTIONS];

    job_result_t expected_ring [RING_DEPTH];
    int          ring_rd = 0;
    int          ring_wr = 0;
    job_result_t oldest;
    int          mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Apply one request to the shadow table and return the result it causes
    function automatic job_result_t next_job_result(input action_t act,
            input logic [CONN_PORT_W-1:0] conn_in, input kind_t kind_in,
            input logic [TAG_BITS-1:0] tag_in);
        job_result_t r;
        int          c;
        int          slot;
        logic        had;
        r.status = ST_IDLE;
        r.conn   = '0;
        r.kind   = KIND_ACCEPT;
        r.tag    = '0;
        c = int'(conn_in) % CONNECTIONS;
        if (act == ACT_SUBMIT)
        begin
            if (!conn_active[c])
            begin
                conn_active[c] = 1'b1;
                r.status = ST_DISPATCHED;
                r.conn   = CONN_PORT_W'(c);
                r.kind   = kind_in;
                r.tag    = tag_in;
            end
            else if (kind_in == KIND_DECODE)
            begin
                had = decode_held[c];
                decode_held[c] = 1'b1;
                decode_tag[c]  = tag_in;
                r.status = had ? ST_PENDING_REPLACED : ST_PENDING_STORED;
            end
            else if (kind_in == KIND_DRAIN)
            begin
                had = drain_held[c];
                drain_held[c] = 1'b1;
                drain_tag[c]  = tag_in;
                r.status = had ? ST_PENDING_REPLACED : ST_PENDING_STORED;
            end
            else if (backlog_fill[c] >= BACKLOG_DEPTH)
            begin
                r.status = ST_BACKLOG_FULL;
            end
            else
            begin
                slot = (backlog_head[c] + backlog_fill[c]) % BACKLOG_DEPTH;
                backlog_kind[c][slot] = kind_in;
                backlog_tag[c][slot]  = tag_in;
                backlog_fill[c]++;
                r.status = ST_BACKLOGGED;
            end
        end
        else
        begin
            if (!conn_active[c])
            begin
                r.status = ST_DONE_UNKNOWN;
            end
            else
            begin
                r.status = ST_DISPATCHED;
                r.conn   = CONN_PORT_W'(c);
                if (drain_held[c] && (!decode_held[c] || prefer_drain[c]))
                begin
                    drain_held[c]   = 1'b0;
                    prefer_drain[c] = 1'b0;
                    r.kind = KIND_DRAIN;
                    r.tag  = drain_tag[c];
                end
                else if (decode_held[c])
                begin
                    decode_held[c]  = 1'b0;
                    prefer_drain[c] = 1'b1;
                    r.kind = KIND_DECODE;
                    r.tag  = decode_tag[c];
                end
                else if (backlog_fill[c] > 0)
                begin
                    slot = backlog_head[c];
                    r.kind = backlog_kind[c][slot];
                    r.tag  = backlog_tag[c][slot];
                    backlog_head[c] = (slot + 1) % BACKLOG_DEPTH;
                    backlog_fill[c]--;
                end
                else
                begin
                    conn_active[c]  = 1'b0;
                    prefer_drain[c] = 1'b0;
                    backlog_head[c] = 0;
                    r.status = ST_IDLE;
                    r.conn   = '0;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CONNECTIONS; c++)
            begin
                conn_active[c]  = 1'b0;
                prefer_drain[c] = 1'b0;
                decode_held[c]  = 1'b0;
                drain_held[c]   = 1'b0;
                backlog_head[c] = 0;
                backlog_fill[c] = 0;
            end
            ring_rd = 0;
            ring_wr = 0;
            outstanding <= 0;
        end
        else
        begin
            // Check the result first: it always belongs to an older request
            if (result_valid === 1'b1)
            begin
                if (ring_wr == ring_rd)
                begin
                    report_mismatch($sformatf("result status %0d with no request waiting",
                                              status));
                end
                else
                begin
                    oldest = expected_ring[ring_rd % RING_DEPTH];
                    ring_rd++;
                    if (status !== oldest.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, oldest.status));
                    if (out_connection !== oldest.conn)
                        report_mismatch($sformatf("out_connection %0d, expected %0d",
                                                  out_connection, oldest.conn));
                    if (out_kind !== oldest.kind)
                        report_mismatch($sformatf("out_kind %0d, expected %0d",
                                                  out_kind, oldest.kind));
                    if (out_tag !== oldest.tag)
                        report_mismatch($sformatf("out_tag %h, expected %h",
                                                  out_tag, oldest.tag));
                end
            end
            if (start && !busy)
            begin
                if (ring_wr - ring_rd >= RING_DEPTH)
                    report_mismatch("too many requests without a result");
                expected_ring[ring_wr % RING_DEPTH] =
                    next_job_result(action_t'(action), connection,
                                    kind_t'(job_kind), job_tag);
                ring_wr++;
            end
            outstanding <= ring_wr - ring_rd;
        end
    end

endmodule

// ----- test/per_connection_job_serializer_tb.sv -----
// Testbench top for the per-connection job serializer: clock, reset, directed
// and random request streams, verdict. Uses pjs_pkg, pjs_result_checker and the RTL.
module per_connection_job_serializer_tb;
    import pjs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAG_BITS = 16;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   action = ACT_SUBMIT;
    logic [CONN_PORT_W-1:0] connection = '0;
    logic [1:0]             job_kind = KIND_ACCEPT;
    logic [TAG_BITS-1:0]    job_tag = '0;
    logic                   result_valid;
    logic [2:0]             status;
    logic [CONN_PORT_W-1:0] out_connection;
    logic [1:0]             out_kind;
    logic [TAG_BITS-1:0]    out_tag;
    int                     fail_count;
    int                     outstanding;

    // Percentage of cycles in which the sender holds start low between requests
    int                     idle_pct = 0;
    // Percentage of random requests that mark a job done
    int                     done_pct = 30;
    // Connections that most random requests go to, so backlogs fill and drain
    logic [CONN_PORT_W-1:0] busy_conns [4];

    per_connection_job_serializer #(.TAG_BITS(TAG_BITS)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .connection(connection),
        .job_kind(job_kind),
        .job_tag(job_tag),
        .result_valid(result_valid),
        .status(status),
        .out_connection(out_connection),
        .out_kind(out_kind),
        .out_tag(out_tag)
    );

    pjs_result_checker #(.TAG_BITS(TAG_BITS)) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .connection(connection),
        .job_kind(job_kind),
        .job_tag(job_tag),
        .result_valid(result_valid),
        .status(status),
        .out_connection(out_connection),
        .out_kind(out_kind),
        .out_tag(out_tag),
        .fail_count(fail_count),
        .outstanding(outstanding)
    );

    always #1 clk = ~clk;

    // Drive one request and hold it until the block takes it. Start is left
    // high on return so that back-to-back requests never drop it for a cycle;
    // the next call lowers it only if it decides to idle first.
    task automatic send_request(input action_t act, input logic [CONN_PORT_W-1:0] conn,
                                input kind_t kind, input logic [TAG_BITS-1:0] tag);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        action     <= act;
        connection <= conn;
        job_kind   <= kind;
        job_tag    <= tag;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Mostly hit the few busy connections; now and then any connection at all
    task automatic send_random_request();
        logic [CONN_PORT_W-1:0] conn;
        action_t                act;
        if ($urandom_range(99) < 80)
            conn = busy_conns[$urandom_range(3)];
        else
            conn = CONN_PORT_W'($urandom_range(CONN_CODES - 1));
        act = ($urandom_range(99) < done_pct) ? ACT_DONE : ACT_SUBMIT;
        send_request(act, conn, kind_t'($urandom_range(3)), TAG_BITS'($urandom));
    endtask

    // Drop start and hold off until every outstanding result has come back
    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial
    begin
        int gap_plan [4];
        gap_plan = '{0, 46, 0, 36};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Walk one connection through every status but backlog full: done while idle,
        // dispatch, pending store and replace, backlog, then the done order
        // with both slots full (decode first, then drain by preference),
        // the backlog in FIFO order and finally back to idle.
        send_request(ACT_DONE,   '0, KIND_ACCEPT, 16'h1234);
        send_request(ACT_SUBMIT, '0, KIND_ACCEPT, 16'h0000);
        send_request(ACT_SUBMIT, '0, KIND_DECODE, 16'hFFFF);
        send_request(ACT_SUBMIT, '0, KIND_DECODE, 16'h5A5A);
        send_request(ACT_SUBMIT, '0, KIND_DRAIN,  16'hA5A5);
        send_request(ACT_SUBMIT, '0, KIND_CLOSE,  16'h0001);
        send_request(ACT_SUBMIT, '0, KIND_ACCEPT, 16'h8000);
        send_request(ACT_DONE,   '0, KIND_CLOSE,  16'hFFFF);
        send_request(ACT_SUBMIT, '0, KIND_DECODE, 16'h00FF);
        send_request(ACT_DONE,   '0, KIND_DRAIN,  16'h0000);
        send_request(ACT_DONE,   '0, KIND_DECODE, 16'h0000);
        send_request(ACT_DONE,   '0, KIND_ACCEPT, 16'h0000);
        send_request(ACT_DONE,   '0, KIND_ACCEPT, 16'h0000);
        send_request(ACT_DONE,   '0, KIND_ACCEPT, 16'h0000);

        // Fill the backlog of the top connection and overflow it once
        send_request(ACT_SUBMIT, 6'd63, KIND_CLOSE, 16'hFFFF);
        for (int i = 0; i < 8; i++)
            send_request(ACT_SUBMIT, 6'd63, (i % 2) ? KIND_CLOSE : KIND_ACCEPT,
                         TAG_BITS'($urandom));
        send_request(ACT_SUBMIT, 6'd63, KIND_ACCEPT, 16'hC3C3);

        // Hold the sender until the block has answered everything
        wait_all_results();

        // Random phases: no idling, heavy sender gaps, no idling, lighter gaps.
        // Done rate swings every few dozen requests so backlogs both fill up
        // to the drop point and drain back to idle.
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = gap_plan[ph];
            for (int h = 0; h < 4; h++)
                busy_conns[h] = CONN_PORT_W'($urandom_range(CONN_CODES - 1));
            for (int n = 0; n < 275; n++)
            begin
                if (n % 40 == 0)
                    done_pct = $urandom_range(15, 65);
                send_random_request();
            end
            wait_all_results();
        end

        // Wait for any stray result to show up
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
